### rtl/core/assert_macros.svh
// assertion macros included by the top-level rtl file
// expects clk and arst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// checked on every rising edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication form
`define ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`endif

### rtl/core/obdr_pkg.sv
// types, constants and character tables for the command responder
// no dependencies
package obdr_pkg;
	typedef enum logic [2:0] {
		K_ID, K_OK, K_RV, K_AT1, K_MASK, K_RPM, K_TEMP, K_ECHO
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  c0;
		logic [7:0]  c1;
		logic [7:0]  c2;
		logic [31:0] data;
	} desc_t;

	localparam logic [31:0] DIV_NUM = 32'hE4E1C000;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_GT = 8'h3E;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_1 = 8'h31;

	localparam logic [7:0] STR_ID [11] = '{8'h45, 8'h4C, 8'h4D, 8'h33, 8'h32, 8'h37,
		8'h20, 8'h76, 8'h31, 8'h2E, 8'h33};
	localparam logic [7:0] STR_RV [5] = '{8'h31, 8'h32, 8'h2E, 8'h36, 8'h56};
	localparam logic [7:0] STR_AT1 [6] = '{8'h46, 8'h46, 8'h6D, 8'h69, 8'h6E, 8'h69};

	function automatic logic [7:0] hex_char(input logic [3:0] n);
		hex_char = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
	endfunction

	// body length, tail of three characters excluded
	function automatic logic [3:0] body_len(input kind_t k);
		case (k)
			K_ID:    body_len = 4'd11;
			K_OK:    body_len = 4'd2;
			K_RV:    body_len = 4'd5;
			K_AT1:   body_len = 4'd6;
			K_MASK:  body_len = 4'd12;
			K_RPM:   body_len = 4'd8;
			K_TEMP:  body_len = 4'd8;
			K_ECHO:  body_len = 4'd4;
			default: body_len = 4'd2;
		endcase
	endfunction

	function automatic logic [7:0] char_at(input desc_t d, input logic [3:0] idx,
			input logic [15:0] v);
		logic [3:0] bl;
		logic [3:0] t;
		logic [7:0] c;
		bl = body_len(d.kind);
		t = idx - bl;
		c = CH_0;
		if (idx >= bl) begin
			c = (t == 4'd1) ? CH_GT : CH_CR;
		end else begin
			case (d.kind)
				K_ID:  c = STR_ID[idx];
				K_OK:  c = (idx == 4'd0) ? 8'h4F : 8'h4B;
				K_RV:  c = STR_RV[idx[2:0]];
				K_AT1: c = STR_AT1[idx[2:0]];
				K_MASK: begin
					case (idx)
						4'd0: c = 8'h34;
						4'd1: c = CH_1;
						4'd2: c = d.c0;
						4'd6: c = (d.c0 == CH_0) ? CH_1 : CH_0;
						4'd10: c = (d.c0 == 8'h32) ? CH_1 : CH_0;
						4'd11: c = (d.c0 == 8'h32) ? 8'h38 : CH_0;
						default: c = CH_0;
					endcase
				end
				K_RPM, K_TEMP: begin
					case (idx)
						4'd0: c = 8'h34;
						4'd1: c = CH_1;
						4'd2: c = (d.kind == K_RPM) ? CH_0 : 8'h33;
						4'd3: c = (d.kind == K_RPM) ? 8'h43 : d.c0;
						4'd4: c = hex_char(v[15:12]);
						4'd5: c = hex_char(v[11:8]);
						4'd6: c = hex_char(v[7:4]);
						default: c = hex_char(v[3:0]);
					endcase
				end
				K_ECHO: begin
					case (idx)
						4'd0: c = 8'h34;
						4'd1: c = d.c0;
						4'd2: c = d.c1;
						default: c = d.c2;
					endcase
				end
				default: c = CH_0;
			endcase
		end
		char_at = c;
	endfunction
endpackage

### rtl/core/obdr_if.sv
// channel interfaces for the command responder
// no dependencies
interface obdr_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  rx_byte;
	logic [15:0] egt_raw;
	logic [15:0] cht_raw;
	logic [31:0] rpm_period;
	modport source(output valid, rx_byte, egt_raw, cht_raw, rpm_period, input ready);
	modport sink(input valid, rx_byte, egt_raw, cht_raw, rpm_period, output ready);
endinterface

interface obdr_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last;
	modport source(output valid, tx_byte, last, input ready);
	modport sink(input valid, tx_byte, last, output ready);
endinterface

### rtl/core/obdr_front.sv
// command parser: classifies received bytes into response descriptors
// depends on obdr_pkg
module obdr_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           acc,
	input  logic [7:0]     b,
	input  logic [15:0]    egt,
	input  logic [15:0]    cht,
	input  logic [31:0]    per,
	output logic           push,
	output obdr_pkg::desc_t pdata
);
	import obdr_pkg::*;

	typedef enum logic [13:0] {
		P_IDLE = 14'h0001, P_A = 14'h0002, P_AT = 14'h0004, P_ARG = 14'h0008,
		P_S = 14'h0010, P_SH = 14'h0020, P_R = 14'h0040, P_ATAT = 14'h0080,
		P_ZERO = 14'h0100, P_D1 = 14'h0200, P_D2 = 14'h0400, P_EP = 14'h0800,
		P_EQ = 14'h1000, P_SKIP = 14'h2000
	} pstate_t;

	pstate_t st_q, st_n;
	logic [2:0] skip_q, skip_n;
	logic [7:0] mode_q, mode_n, pid_q, pid_n;
	logic resp;
	desc_t d;
	logic [15:0] raw;
	logic [15:0] tcode;

	assign raw = (b == 8'h43) ? egt : cht;
	assign tcode = raw[2] ? 16'd0 :
		({3'd0, raw[14:3], 1'b0} + {5'd0, raw[14:4]} + 16'd400);

	always_comb begin
		st_n = P_IDLE;
		skip_n = skip_q;
		mode_n = mode_q;
		pid_n = pid_q;
		resp = 1'b0;
		d = '{kind: K_OK, c0: b, c1: pid_q, c2: b, data: per};
		case (st_q)
			P_A: if (b == 8'h54) st_n = P_AT;
			P_AT: begin
				case (b)
					8'h5A, 8'h49: begin resp = 1'b1; d.kind = K_ID; end
					8'h45, 8'h4D, 8'h4C, 8'h48, 8'h56: st_n = P_ARG;
					8'h53: st_n = P_S;
					8'h52: st_n = P_R;
					8'h40: st_n = P_ATAT;
					8'h31: resp = 1'b1;
					default: st_n = P_IDLE;
				endcase
			end
			P_ARG: resp = 1'b1;
			P_S: begin
				if (b == 8'h48) begin
					st_n = P_SH;
					skip_n = 3'd6;
				end else if (b == 8'h50) st_n = P_ARG;
				else resp = 1'b1;
			end
			P_SH: begin
				if (skip_q > 3'd1) begin
					skip_n = skip_q - 3'd1;
					st_n = P_SH;
				end else resp = 1'b1;
			end
			P_R: begin
				resp = 1'b1;
				if (b == 8'h56) d.kind = K_RV;
			end
			P_ATAT: begin
				resp = 1'b1;
				if (b == 8'h31) d.kind = K_AT1;
			end
			P_ZERO: begin
				mode_n = b;
				if (b == 8'h31) st_n = P_D1;
				else if ((b >= 8'h32 && b <= 8'h39) || b == 8'h41) st_n = P_EP;
			end
			P_D1: begin
				pid_n = b;
				st_n = P_D2;
			end
			P_D2: begin
				d.c0 = pid_q;
				if (b == CH_0) begin
					resp = 1'b1;
					d.kind = K_MASK;
				end else if (pid_q == CH_0 && b == 8'h43) begin
					resp = 1'b1;
					d.kind = K_RPM;
				end else if (pid_q == 8'h33 && (b == 8'h43 || b == 8'h44)) begin
					resp = 1'b1;
					d.kind = K_TEMP;
					d.c0 = b;
					d.data = {16'd0, tcode};
				end
			end
			P_EP: begin
				pid_n = b;
				st_n = P_EQ;
			end
			P_EQ: begin
				resp = 1'b1;
				d.kind = K_ECHO;
				d.c0 = mode_q;
			end
			P_SKIP: begin
				if (skip_q > 3'd1) begin
					skip_n = skip_q - 3'd1;
					st_n = P_SKIP;
				end else skip_n = 3'd0;
			end
			default: begin
				if (b == 8'h41) st_n = P_A;
				else if (b == CH_0) st_n = P_ZERO;
			end
		endcase
		if (resp) begin
			st_n = P_SKIP;
			skip_n = 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= P_IDLE;
			skip_q <= 3'd0;
			mode_q <= 8'd0;
			pid_q <= 8'd0;
		end else if (acc) begin
			st_q <= st_n;
			skip_q <= skip_n;
			mode_q <= mode_n;
			pid_q <= pid_n;
		end
	end

	assign push = acc & resp;
	assign pdata = d;
endmodule

### rtl/core/obdr_queue.sv
// two-entry descriptor queue between parser and emitter
// depends on obdr_pkg
module obdr_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  obdr_pkg::desc_t wdata,
	input  logic            pop,
	output logic            full,
	output logic            nempty,
	output obdr_pkg::desc_t rdata
);
	import obdr_pkg::*;

	desc_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	assign full = cnt_q[1];
	assign nempty = (cnt_q != 2'd0);
	assign rdata = mem_q[rp_q];
endmodule

### rtl/core/obdr_back.sv
// response emitter: rpm divider and character sequencer with output register
// depends on obdr_pkg
module obdr_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_nempty,
	input  obdr_pkg::desc_t q_data,
	output logic            q_pop,
	output logic            tvalid,
	input  logic            tready,
	output logic [7:0]      tbyte,
	output logic            tlast
);
	import obdr_pkg::*;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001, B_DIV = 3'b010, B_EMIT = 3'b100
	} bstate_t;

	bstate_t st_q;
	desc_t cur_q;
	logic [15:0] val_q;
	logic [3:0] idx_q;
	logic [31:0] rem_q;
	logic [31:0] dvd_q;
	logic [4:0] cnt_q;
	logic tvalid_q, tlast_q;
	logic [7:0] tbyte_q;
	logic [32:0] rem_sh, rem_sub;
	logic ge, is_last, slot;

	assign rem_sh = {rem_q, dvd_q[31]};
	assign rem_sub = rem_sh - {1'b0, cur_q.data};
	assign ge = ~rem_sub[32];
	assign is_last = (idx_q == body_len(cur_q.kind) + 4'd2);
	assign slot = !tvalid_q || tready;
	assign q_pop = (st_q == B_IDLE) && q_nempty;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
			val_q <= (q_data.kind == K_RPM) ? 16'd0 : q_data.data[15:0];
			dvd_q <= DIV_NUM;
			rem_q <= '0;
		end else if (st_q == B_DIV) begin
			rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
			dvd_q <= {dvd_q[30:0], ge};
			if (cnt_q == 5'd31) val_q <= {dvd_q[14:0], ge};
		end
		if (st_q == B_EMIT && slot) begin
			tbyte_q <= char_at(cur_q, idx_q, val_q);
			tlast_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
			idx_q <= 4'd0;
			cnt_q <= 5'd0;
			tvalid_q <= 1'b0;
		end else begin
			// output register: load a new character or drain the taken one
			if (st_q == B_EMIT && slot) tvalid_q <= 1'b1;
			else if (tready) tvalid_q <= 1'b0;
			case (st_q)
				B_IDLE: begin
					idx_q <= 4'd0;
					cnt_q <= 5'd0;
					if (q_nempty) begin
						st_q <= (q_data.kind == K_RPM && q_data.data != 32'd0) ? B_DIV : B_EMIT;
					end
				end
				B_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) st_q <= B_EMIT;
				end
				B_EMIT: begin
					if (slot) begin
						idx_q <= idx_q + 4'd1;
						if (is_last) st_q <= B_IDLE;
					end
				end
				default: st_q <= B_IDLE;
			endcase
		end
	end

	assign tvalid = tvalid_q;
	assign tbyte = tbyte_q;
	assign tlast = tlast_q;
endmodule

### rtl/core/obd_at_command_responder.sv
// top level of the command responder: parser, descriptor queue, emitter
// depends on obdr_pkg, obdr_if, obdr_front, obdr_queue, obdr_back, assert_macros.svh

// Takes one received command byte per rx beat together with the sensor words and
// answers complete AT or mode 01..0A commands on tx, one character per beat, with
// last marking the final character (the trailing CR) of each response. A beat is
// taken when the two-entry response queue has room; bytes that complete no command
// leave no tx beats. An rpm response with a nonzero period passes through the restoring
// divider (one quotient bit per cycle) before its characters go out; each response, of
// 5 to 15 characters, goes out as tx takes it; the next entry is fetched only after
// its last character. Sensor words are sampled on the beat that completes a command.
module obd_at_command_responder (
	input logic clk,
	input logic arst_n,
	obdr_in_if.sink    rx,
	obdr_out_if.source tx
);
	import obdr_pkg::*;

	logic acc, push, pop, full, nempty;
	desc_t pdata, qdata;

	// parser stalls only on a full queue
	assign rx.ready = !full;
	assign acc = rx.valid && rx.ready;

	obdr_front u_front (
		.clk(clk), .arst_n(arst_n), .acc(acc), .b(rx.rx_byte),
		.egt(rx.egt_raw), .cht(rx.cht_raw), .per(rx.rpm_period),
		.push(push), .pdata(pdata)
	);

	obdr_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(pdata),
		.pop(pop), .full(full), .nempty(nempty), .rdata(qdata)
	);

	obdr_back u_back (
		.clk(clk), .arst_n(arst_n), .q_nempty(nempty), .q_data(qdata),
		.q_pop(pop), .tvalid(tx.valid), .tready(tx.ready),
		.tbyte(tx.tx_byte), .tlast(tx.last)
	);

`include "assert_macros.svh"
	`ASSERT_IMPL(a_push_room, push, !full, "descriptor pushed into full queue")
	`ASSERT_IMPL(a_pop_data, pop, nempty, "descriptor popped from empty queue")
	`ASSERT_CLK(a_no_push_idle, !(push && !acc), "descriptor pushed without rx beat")
endmodule
